FILE: hdl/sfbc_pkg.sv
// sfbc_pkg: types and codes shared by the sync fault backoff controller
// no dependencies
`default_nettype none

package sfbc_pkg;

    localparam int unsigned LadderW = 27;
    localparam int unsigned CapW    = 22;
    localparam int unsigned RetryW  = 31;
    localparam int unsigned StatusW = 10;
    localparam int unsigned StreakW = 8;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [LadderW-1:0] LadderFirstRst  = LadderW'(30 * 1000);
    localparam logic [LadderW-1:0] LadderSecondRst = LadderW'(2 * 60 * 1000);
    localparam logic [LadderW-1:0] LadderThirdRst  = LadderW'(10 * 60 * 1000);
    localparam logic [CapW-1:0]    RetryCapRst     = CapW'(24 * 60 * 60);

    localparam logic [StatusW-1:0] StatusOk   = StatusW'(200);
    localparam logic [StatusW-1:0] StatusProv = StatusW'(401);
    localparam logic [StatusW-1:0] StatusBusy = StatusW'(503);

    localparam logic [RetryW-1:0]  MsMax      = {RetryW{1'b1}};
    localparam logic [StreakW-1:0] StreakMax  = {StreakW{1'b1}};

    typedef enum logic [CfgIdxW-1:0] {
        REG_LADDER_FIRST  = 2'd0,
        REG_LADDER_SECOND = 2'd1,
        REG_LADDER_THIRD  = 2'd2,
        REG_RETRY_CAP     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        OUTCOME_OK    = 2'd0,
        OUTCOME_TRUST = 2'd1,
        OUTCOME_XPORT = 2'd2
    } t_outcome;

    localparam logic [2:0] FAULT_NONE   = 3'd0;
    localparam logic [2:0] FAULT_HOME   = 3'd1;
    localparam logic [2:0] FAULT_NOSIG  = 3'd2;
    localparam logic [2:0] FAULT_PROV   = 3'd3;
    localparam logic [2:0] FAULT_BUSY   = 3'd4;
    localparam logic [2:0] FAULT_SERVER = 3'd5;

    localparam logic [1:0] KIND_LADDER = 2'd0;
    localparam logic [1:0] KIND_RETRY  = 2'd1;
    localparam logic [1:0] KIND_HALT   = 2'd2;
    localparam logic [1:0] KIND_WAKE   = 2'd3;

    typedef struct packed {
        logic               command;
        logic [1:0]         outcome;
        logic [StatusW-1:0] status_code;
        logic [RetryW-1:0]  retry_secs;
        logic               decode_failed;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         fault;
        logic [1:0]         delay_kind;
        logic [RetryW-1:0]  delay_ms;
        logic [StreakW-1:0] failure_count;
    } t_out_item;

    typedef struct packed {
        logic [LadderW-1:0] ladder_first_ms;
        logic [LadderW-1:0] ladder_second_ms;
        logic [LadderW-1:0] ladder_third_ms;
        logic [CapW-1:0]    retry_after_cap_s;
    } t_cfg;

endpackage

`default_nettype wire

FILE: hdl/sfbc_classify.sv
// sfbc_classify: turns an attempt report into a fault code
// depends on sfbc_pkg
`default_nettype none

module sfbc_classify (
    input  wire sfbc_pkg::t_in_item i_item,
    output logic [2:0]              o_fault
);
    import sfbc_pkg::*;

    always_comb begin
        case (i_item.outcome)
            OUTCOME_OK: begin
                if (i_item.status_code == StatusOk) begin
                    o_fault = i_item.decode_failed ? FAULT_SERVER : FAULT_NONE;
                end else if (i_item.status_code == StatusProv) begin
                    o_fault = FAULT_PROV;
                end else if (i_item.status_code == StatusBusy) begin
                    o_fault = FAULT_BUSY;
                end else begin
                    o_fault = FAULT_SERVER;
                end
            end
            OUTCOME_TRUST: o_fault = FAULT_HOME;
            default:       o_fault = FAULT_NOSIG;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/sfbc_backoff.sv
// sfbc_backoff: backoff state registers, state update and delay selection
// depends on sfbc_pkg
`default_nettype none

module sfbc_backoff (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_fire,
    input  wire                      i_command,
    input  wire [2:0]                i_fault,
    input  wire [sfbc_pkg::RetryW-1:0] i_retry_s,
    input  wire sfbc_pkg::t_cfg      i_cfg,
    output sfbc_pkg::t_out_item      o_result
);
    import sfbc_pkg::*;

    logic [StreakW-1:0] r_streak, n_streak;
    logic [RetryW-1:0]  r_held,   n_held;
    logic               r_halt,   n_halt;

    logic [CapW-1:0]   clamp_s;
    logic [31:0]       prod_ms;
    logic [RetryW-1:0] busy_ms;

    // retry-after clamped to the cap, in ms, saturated
    always_comb begin
        clamp_s = (i_retry_s < {{(RetryW-CapW){1'b0}}, i_cfg.retry_after_cap_s})
                  ? i_retry_s[CapW-1:0] : i_cfg.retry_after_cap_s;
        prod_ms = {{(32-CapW){1'b0}}, clamp_s} * 32'd1000;
        busy_ms = prod_ms[31] ? MsMax : prod_ms[RetryW-1:0];
    end

    always_comb begin
        n_streak = r_streak;
        n_held   = r_held;
        n_halt   = r_halt;
        if (i_fire) begin
            if (i_command || i_fault == FAULT_NONE) begin
                n_streak = '0;
                n_held   = '0;
                n_halt   = 1'b0;
            end else if (i_fault == FAULT_PROV) begin
                n_halt = 1'b1;
                n_held = '0;
            end else if (i_fault == FAULT_BUSY && i_retry_s != '0) begin
                n_held = busy_ms;
            end else begin
                n_held = '0;
                if (r_streak != StreakMax) begin
                    n_streak = r_streak + StreakW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streak <= '0;
            r_held   <= '0;
            r_halt   <= 1'b0;
        end else begin
            r_streak <= n_streak;
            r_held   <= n_held;
            r_halt   <= n_halt;
        end
    end

    always_comb begin
        o_result.fault         = i_command ? FAULT_NONE : i_fault;
        o_result.failure_count = n_streak;
        o_result.delay_ms      = '0;
        if (n_halt) begin
            o_result.delay_kind = KIND_HALT;
        end else if (n_held != '0) begin
            o_result.delay_kind = KIND_RETRY;
            o_result.delay_ms   = n_held;
        end else begin
            case (n_streak)
                StreakW'(1): begin
                    o_result.delay_kind = KIND_LADDER;
                    o_result.delay_ms   = {{(RetryW-LadderW){1'b0}}, i_cfg.ladder_first_ms};
                end
                StreakW'(2): begin
                    o_result.delay_kind = KIND_LADDER;
                    o_result.delay_ms   = {{(RetryW-LadderW){1'b0}}, i_cfg.ladder_second_ms};
                end
                StreakW'(3): begin
                    o_result.delay_kind = KIND_LADDER;
                    o_result.delay_ms   = {{(RetryW-LadderW){1'b0}}, i_cfg.ladder_third_ms};
                end
                default: o_result.delay_kind = KIND_WAKE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sync_fault_backoff_controller_unit.sv
// sync_fault_backoff_controller_unit: top level, config registers and pipeline
// depends on sfbc_pkg, sfbc_classify, sfbc_backoff
//
// Each input transaction is a sync-attempt report or a user press; each one
// gives exactly one result transaction with the fault code, the next delay
// kind and value, and the consecutive failure count.
// Input channel: i_in_valid / o_in_stall / i_in_data, accepted when valid is
// high and stall is low. Output channel: o_out_valid / i_out_stall /
// o_out_data, taken likewise.
// Classification and backoff update run between the input register and the
// result register. Throughput is one transaction per cycle while the output
// is not stalled, set by the state update loop in the backoff stage.
// A stall on the output holds the result register; the input register
// still fills, after which o_in_stall rises until the output drains.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect on the
// next edge; the user must make them while the block is idle, and no logic in
// the block enforces that. Synchronous reset empties both registers, clears
// the backoff state and restores the register defaults.
`default_nettype none

module sync_fault_backoff_controller_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [sfbc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire [sfbc_pkg::LadderW-1:0]  i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire sfbc_pkg::t_in_item      i_in_data,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output sfbc_pkg::t_out_item          o_out_data
);
    import sfbc_pkg::*;

    t_cfg      r_cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;

    logic      advance;
    logic      in_take;
    logic [2:0] fault;
    t_out_item result;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ladder_first_ms   <= LadderFirstRst;
            r_cfg.ladder_second_ms  <= LadderSecondRst;
            r_cfg.ladder_third_ms   <= LadderThirdRst;
            r_cfg.retry_after_cap_s <= RetryCapRst;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_LADDER_FIRST:  r_cfg.ladder_first_ms  <= i_cfg_data;
                REG_LADDER_SECOND: r_cfg.ladder_second_ms <= i_cfg_data;
                REG_LADDER_THIRD:  r_cfg.ladder_third_ms  <= i_cfg_data;
                REG_RETRY_CAP:     r_cfg.retry_after_cap_s <= i_cfg_data[CapW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    sfbc_classify u_classify (
        .i_item  (r_in),
        .o_fault (fault)
    );

    sfbc_backoff u_backoff (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_command (r_in.command),
        .i_fault   (fault),
        .i_retry_s (r_in.retry_secs),
        .i_cfg     (r_cfg),
        .o_result  (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_prov_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fault == FAULT_PROV) |-> (r_out.delay_kind == KIND_HALT))
        else $error("provisioning fault without halt");

    a_ok_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fault == FAULT_NONE)
        |-> (r_out.delay_kind == KIND_WAKE && r_out.failure_count == '0))
        else $error("success or press did not clear backoff");

    a_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.delay_kind == KIND_HALT || r_out.delay_kind == KIND_WAKE))
        |-> (r_out.delay_ms == '0))
        else $error("nonzero delay for halt or wake");

    a_ladder_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.delay_kind == KIND_LADDER)
        |-> (r_out.failure_count != '0 && r_out.failure_count <= StreakW'(3)))
        else $error("ladder delay with streak outside first three");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while pipeline blocked");

endmodule

`default_nettype wire

FILE: dv/sync_fault_backoff_controller_unit_tb.sv
// sync_fault_backoff_controller_unit_tb: self-checking bench for the backoff controller
// depends on sfbc_pkg and sync_fault_backoff_controller_unit; a local predictor
// tracks the backoff state and checks every result transaction in order
`default_nettype none

module sync_fault_backoff_controller_unit_tb;

    import sfbc_pkg::*;

    localparam logic [1:0] OutcomeSpare = 2'd3;
    localparam int unsigned CycleLimit  = 1000000;
    localparam logic [LadderW-1:0] LadderAllOnes = {LadderW{1'b1}};

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    t_reg_idx  i_cfg_index = REG_LADDER_FIRST;
    logic [LadderW-1:0] i_cfg_data = '0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    sync_fault_backoff_controller_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of registers and backoff state
    logic [LadderW-1:0] cfg_lad1 = LadderFirstRst;
    logic [LadderW-1:0] cfg_lad2 = LadderSecondRst;
    logic [LadderW-1:0] cfg_lad3 = LadderThirdRst;
    logic [CapW-1:0]    cfg_cap  = RetryCapRst;
    logic [StreakW-1:0] streak   = '0;
    logic [RetryW-1:0]  held_ms  = '0;
    logic               halted   = 1'b0;

    t_in_item    pending_reports[$];
    t_out_item   expected_results[$];
    bit          offer_live = 1'b0;
    bit          quiet_phase = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned gap_roll;
    int unsigned stall_roll;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    function automatic t_out_item predict_backoff(t_in_item it);
        t_out_item       res;
        logic [2:0]      flt;
        logic [CapW-1:0] secs;
        logic [47:0]     ms;
        flt = FAULT_NONE;
        if (!it.command) begin
            if (it.outcome == OUTCOME_TRUST) flt = FAULT_HOME;
            else if (it.outcome != OUTCOME_OK) flt = FAULT_NOSIG;
            else if (it.status_code == StatusOk) flt = it.decode_failed ? FAULT_SERVER : FAULT_NONE;
            else if (it.status_code == StatusProv) flt = FAULT_PROV;
            else if (it.status_code == StatusBusy) flt = FAULT_BUSY;
            else flt = FAULT_SERVER;
        end
        if (flt == FAULT_NONE) begin
            streak  = '0;
            held_ms = '0;
            halted  = 1'b0;
        end else if (flt == FAULT_PROV) begin
            halted  = 1'b1;
            held_ms = '0;
        end else if (flt == FAULT_BUSY && it.retry_secs != '0) begin
            secs = (it.retry_secs < RetryW'(cfg_cap)) ? CapW'(it.retry_secs) : cfg_cap;
            ms = 48'(secs) * 48'd1000;
            held_ms = (ms > 48'(MsMax)) ? MsMax : ms[RetryW-1:0];
        end else begin
            held_ms = '0;
            if (streak != StreakMax) streak = streak + StreakW'(1);
        end
        res.fault = flt;
        res.delay_ms = '0;
        res.failure_count = streak;
        if (halted) begin
            res.delay_kind = KIND_HALT;
        end else if (held_ms != '0) begin
            res.delay_kind = KIND_RETRY;
            res.delay_ms = held_ms;
        end else begin
            case (streak)
                8'd1: begin
                    res.delay_kind = KIND_LADDER;
                    res.delay_ms = RetryW'(cfg_lad1);
                end
                8'd2: begin
                    res.delay_kind = KIND_LADDER;
                    res.delay_ms = RetryW'(cfg_lad2);
                end
                8'd3: begin
                    res.delay_kind = KIND_LADDER;
                    res.delay_ms = RetryW'(cfg_lad3);
                end
                default: res.delay_kind = KIND_WAKE;
            endcase
        end
        return res;
    endfunction

    function automatic t_in_item make_report(logic cmd, logic [1:0] oc, int unsigned status,
                                             int unsigned retry, logic dec);
        t_in_item it;
        it.command = cmd;
        it.outcome = oc;
        it.status_code = StatusW'(status);
        it.retry_secs = RetryW'(retry);
        it.decode_failed = dec;
        return it;
    endfunction

    function automatic void add_report(t_in_item it);
        pending_reports.insert(pending_reports.size(), it);
    endfunction

    // calm is the percentage of presses and clean successes
    function automatic t_in_item rand_report(int unsigned calm);
        t_in_item    it;
        int unsigned r;
        it.command = 1'b0;
        it.outcome = OUTCOME_OK;
        it.status_code = StatusW'($urandom_range(0, 1023));
        it.retry_secs = RetryW'($urandom());
        it.decode_failed = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < calm / 2) begin
            it.command = 1'b1;
            it.outcome = 2'($urandom_range(0, 3));
        end else if (r < calm) begin
            it.status_code = StatusOk;
            it.decode_failed = 1'b0;
        end else begin
            case ($urandom_range(0, 9))
                0: it.outcome = OUTCOME_TRUST;
                1: it.outcome = $urandom_range(0, 1) ? OUTCOME_XPORT : OutcomeSpare;
                2: it.status_code = StatusProv;
                3, 4: begin
                    it.status_code = StatusBusy;
                    case ($urandom_range(0, 4))
                        0: it.retry_secs = '0;
                        1, 2: it.retry_secs = RetryW'($urandom_range(1, 300));
                        3: it.retry_secs = RetryW'(cfg_cap) + RetryW'($urandom_range(0, 2))
                                           - RetryW'(1);
                        default: ;
                    endcase
                end
                5: begin
                    it.status_code = StatusOk;
                    it.decode_failed = 1'b1;
                end
                6: it.status_code = StatusW'($urandom_range(500, 599));
                7: it.outcome = 2'($urandom_range(0, 3));
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    // input acceptance, prediction and result check share one edge process
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.insert(expected_results.size(), predict_backoff(i_in_data));
                offer_live = 1'b0;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result transaction, expected none actual %h",
                             $time, o_out_data);
                end else begin
                    t_out_item want;
                    want = expected_results.pop_front();
                    check_field("fault", 32'(want.fault), 32'(o_out_data.fault));
                    check_field("delay_kind", 32'(want.delay_kind), 32'(o_out_data.delay_kind));
                    check_field("delay_ms", 32'(want.delay_ms), 32'(o_out_data.delay_ms));
                    check_field("failure_count", 32'(want.failure_count),
                                32'(o_out_data.failure_count));
                end
            end
        end
        if (cycle_count > CycleLimit) begin
            $display("%0t: timeout", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // driver: one transaction on offer at a time, random gaps between them
    always @(negedge i_clk) begin
        if (!offer_live) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reports.size() != 0) begin
                i_in_data <= pending_reports.pop_front();
                i_in_valid <= 1'b1;
                offer_live = 1'b1;
                gap_roll = $urandom_range(0, 99);
                if (quiet_phase || gap_roll < 60) gap_left = 0;
                else if (gap_roll < 92) gap_left = $urandom_range(1, 3);
                else gap_left = $urandom_range(8, 40);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall in segments of random length
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (quiet_phase || stall_roll < 50) begin
                i_out_stall <= 1'b0;
                stall_left = $urandom_range(1, 6);
            end else if (stall_roll < 90) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(1, 3);
            end else begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(10, 50);
            end
        end
    end

    task automatic wait_drained();
        while (pending_reports.size() != 0 || offer_live || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [LadderW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LADDER_FIRST:  cfg_lad1 = val;
            REG_LADDER_SECOND: cfg_lad2 = val;
            REG_LADDER_THIRD:  cfg_lad3 = val;
            REG_RETRY_CAP:     cfg_cap = val[CapW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [LadderW-1:0] l1, logic [LadderW-1:0] l2,
                              logic [LadderW-1:0] l3, logic [LadderW-1:0] cap);
        write_reg(REG_LADDER_FIRST, l1);
        write_reg(REG_LADDER_SECOND, l2);
        write_reg(REG_LADDER_THIRD, l3);
        write_reg(REG_RETRY_CAP, cap);
    endtask

    task automatic run_reports(int unsigned n, int unsigned calm, bit quiet);
        quiet_phase = quiet;
        repeat (n) add_report(rand_report(calm));
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed sequence at register defaults
        add_report(make_report(1'b1, OutcomeSpare, 1023, {1'b0, MsMax}, 1'b1));
        add_report(make_report(1'b0, OUTCOME_OK, 200, 0, 1'b0));
        add_report(make_report(1'b0, OUTCOME_TRUST, 401, 7, 1'b1));
        add_report(make_report(1'b0, OUTCOME_XPORT, 200, 0, 1'b0));
        add_report(make_report(1'b0, OutcomeSpare, 503, 30, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 500, 0, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 200, 0, 1'b1));
        add_report(make_report(1'b0, OUTCOME_OK, 404, 0, 1'b1));
        add_report(make_report(1'b0, OUTCOME_OK, 503, 0, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 503, 120, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 503, {1'b0, MsMax}, 1'b0));
        add_report(make_report(1'b0, OUTCOME_TRUST, 200, 0, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 401, 60, 1'b0));
        add_report(make_report(1'b0, OUTCOME_TRUST, 200, 0, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 503, 5, 1'b0));
        add_report(make_report(1'b1, OUTCOME_OK, 401, 0, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 401, 0, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 200, 9, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 503, 1, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 0, 0, 1'b0));
        add_report(make_report(1'b0, OUTCOME_OK, 1023, 0, 1'b1));
        add_report(make_report(1'b0, OUTCOME_OK, 503, 86401, 1'b0));
        add_report(make_report(1'b1, OUTCOME_OK, 200, 0, 1'b0));
        wait_drained();

        run_reports(300, 30, 1'b0);

        set_config(LadderW'($urandom()), LadderW'($urandom()), LadderW'($urandom()),
                   LadderW'($urandom()));
        run_reports(250, 25, 1'b0);

        // zero cap: busy with retry-after leaves the ladder in charge
        set_config('0, '0, '0, '0);
        run_reports(200, 30, 1'b0);

        // widest values, cap overflow saturates the held delay
        set_config(LadderAllOnes, LadderAllOnes, LadderAllOnes, LadderAllOnes);
        run_reports(250, 20, 1'b1);

        // failure storm with no presses or planned successes, drives the streak into saturation
        set_config(LadderW'($urandom()), LadderW'($urandom()), LadderW'($urandom()),
                   LadderW'(1));
        run_reports(400, 0, 1'b0);

        set_config(LadderW'(86400000), LadderW'(86400000), LadderW'(86400000),
                   LadderW'(2147483));
        run_reports(250, 30, 1'b0);

        set_config(LadderW'($urandom_range(0, 1000)), LadderW'($urandom()),
                   LadderW'($urandom()), LadderW'($urandom_range(1, 1000)));
        run_reports(230, 40, 1'b0);

        repeat (10) @(posedge i_clk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
